[hw/rtl/tlb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tlb_pkg;

    // fixed field widths
    localparam int OP_W   = 3;
    localparam int RES_W  = 3;
    localparam int VPN_W  = 36;
    localparam int OFF_W  = 12;
    localparam int PPN_W  = 28;
    localparam int PA_W   = 40;
    localparam int CNT_W  = 32;
    localparam int NUM_CNT = 6;

    // default geometry
    localparam int DEF_L1_ENTRIES = 16;
    localparam int DEF_L2_ENTRIES = 64;
    localparam int DEF_STAMP_BITS = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_TR_RD   = 3'd0;
    localparam logic [OP_W-1:0] OP_TR_WR   = 3'd1;
    localparam logic [OP_W-1:0] OP_INVAL   = 3'd2;
    localparam logic [OP_W-1:0] OP_FILL_RD = 3'd3;
    localparam logic [OP_W-1:0] OP_FILL_WR = 3'd4;

    // outcome codes
    localparam logic [RES_W-1:0] RES_L1_HIT = 3'd0;
    localparam logic [RES_W-1:0] RES_L2_HIT = 3'd1;
    localparam logic [RES_W-1:0] RES_WALK   = 3'd2;
    localparam logic [RES_W-1:0] RES_FILLED = 3'd3;
    localparam logic [RES_W-1:0] RES_INVAL  = 3'd4;

    // event counter slots
    localparam int CNT_L1_HIT   = 0;
    localparam int CNT_L1_MISS  = 1;
    localparam int CNT_L2_HIT   = 2;
    localparam int CNT_L2_MISS  = 3;
    localparam int CNT_L1_INVAL = 4;
    localparam int CNT_L2_INVAL = 5;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan1;
        logic scan2;
        logic l1_hit_upd;
        logic l1_inval;
        logic l2_hit_upd;
        logic l2_miss;
        logic l2_inval;
        logic l2_fill;
        logic l2_move;
        logic l1_promote;
        logic l1_fill;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last1;
        logic last2;
        logic hit1;
        logic hit2;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[hw/rtl/tlb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/tlb_scan.sv]
`timescale 1ns / 1ps
`default_nettype none

module tlb_scan #(
    parameter int IW = 4,
    parameter int SB = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_clr,
    input  wire logic                      i_ev,
    input  wire logic [IW-1:0]             i_idx,
    input  wire logic                      i_vld,
    input  wire logic [tlb_pkg::VPN_W-1:0] i_key,
    input  wire logic                      i_skip_en,
    input  wire logic                      i_dirty,
    input  wire logic [SB-1:0]             i_stamp,
    input  wire logic [tlb_pkg::VPN_W-1:0] i_vpage,
    input  wire logic [tlb_pkg::PPN_W-1:0] i_ppage,
    output logic                           o_hit,
    output logic      [IW-1:0]             o_hidx,
    output logic                           o_hdirty,
    output logic      [tlb_pkg::PPN_W-1:0] o_hppage,
    output logic      [IW-1:0]             o_vidx,
    output logic                           o_vmove,
    output logic      [SB-1:0]             o_vstamp,
    output logic      [tlb_pkg::VPN_W-1:0] o_vvpage,
    output logic      [tlb_pkg::PPN_W-1:0] o_vppage
);

    logic                      r_hit;
    logic [IW-1:0]             r_hidx;
    logic                      r_hdirty;
    logic [tlb_pkg::PPN_W-1:0] r_hppage;
    logic                      r_inv;
    logic [IW-1:0]             r_invidx;
    logic                      r_have;
    logic [IW-1:0]             r_midx;
    logic [SB-1:0]             r_mstamp;
    logic                      r_mdirty;
    logic [tlb_pkg::VPN_W-1:0] r_mvpage;
    logic [tlb_pkg::PPN_W-1:0] r_mppage;

    logic w_first;
    logic w_take_inv;
    logic w_take_min;

    // per-entry evaluation: first match, first free slot, oldest stamp
    assign w_first    = i_ev && i_vld && (i_vpage == i_key) && !r_hit;
    assign w_take_inv = i_ev && !i_vld && !r_inv;
    assign w_take_min = i_ev && !(i_skip_en && w_first) &&
                        (!r_have || (i_stamp < r_mstamp));

    // tracker flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_hit  <= 1'b0;
            r_inv  <= 1'b0;
            r_have <= 1'b0;
        end else begin
            if (w_first) begin
                r_hit <= 1'b1;
            end
            if (w_take_inv) begin
                r_inv <= 1'b1;
            end
            if (w_take_min) begin
                r_have <= 1'b1;
            end
        end
    end

    // captured entry contents
    always_ff @(posedge i_clk) begin
        if (w_first) begin
            r_hidx   <= i_idx;
            r_hdirty <= i_dirty;
            r_hppage <= i_ppage;
        end
        if (w_take_inv) begin
            r_invidx <= i_idx;
        end
        if (w_take_min) begin
            r_midx   <= i_idx;
            r_mstamp <= i_stamp;
            r_mdirty <= i_dirty;
            r_mvpage <= i_vpage;
            r_mppage <= i_ppage;
        end
    end

    assign o_hit    = r_hit;
    assign o_hidx   = r_hidx;
    assign o_hdirty = r_hdirty;
    assign o_hppage = r_hppage;
    assign o_vidx   = r_inv ? r_invidx : r_midx;
    assign o_vmove  = !r_inv && r_mdirty;
    assign o_vstamp = r_mstamp;
    assign o_vvpage = r_mvpage;
    assign o_vppage = r_mppage;

endmodule

`default_nettype wire

[hw/rtl/tlb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module tlb_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [tlb_pkg::OP_W-1:0] i_operation,
    output logic                          o_stall,
    input  wire tlb_pkg::t_sts            i_sts,
    output tlb_pkg::t_cmd                 o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN1 = 4'd1;
    localparam logic [3:0] S_GAP1  = 4'd2;
    localparam logic [3:0] S_DEC1  = 4'd3;
    localparam logic [3:0] S_SCAN2 = 4'd4;
    localparam logic [3:0] S_GAP2  = 4'd5;
    localparam logic [3:0] S_DEC2  = 4'd6;
    localparam logic [3:0] S_WR2   = 4'd7;
    localparam logic [3:0] S_WR3   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic [tlb_pkg::OP_W-1:0]  r_op;
    logic                      w_is_tr;
    logic                      w_is_fill;

    assign w_is_tr   = (r_op == tlb_pkg::OP_TR_RD) || (r_op == tlb_pkg::OP_TR_WR);
    assign w_is_fill = (r_op == tlb_pkg::OP_FILL_RD) || (r_op == tlb_pkg::OP_FILL_WR);
    assign o_stall   = (r_state != S_IDLE);

    // sequencing of one transaction
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && (i_operation <= tlb_pkg::OP_FILL_WR)) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN1;
                end
            end
            S_SCAN1: begin
                o_cmd.scan1 = 1'b1;
                if (i_sts.last1) begin
                    n_state = S_GAP1;
                end
            end
            S_GAP1: begin
                n_state = S_DEC1;
            end
            S_DEC1: begin
                if (w_is_tr && i_sts.hit1) begin
                    o_cmd.l1_hit_upd = 1'b1;
                    n_state          = S_OUT;
                end else begin
                    o_cmd.l1_inval = (r_op == tlb_pkg::OP_INVAL);
                    n_state        = S_SCAN2;
                end
            end
            S_SCAN2: begin
                o_cmd.scan2 = 1'b1;
                if (i_sts.last2) begin
                    n_state = S_GAP2;
                end
            end
            S_GAP2: begin
                n_state = S_DEC2;
            end
            S_DEC2: begin
                if (w_is_fill) begin
                    o_cmd.l2_fill = 1'b1;
                    n_state       = S_WR3;
                end else if (!w_is_tr) begin
                    o_cmd.l2_inval = 1'b1;
                    n_state        = S_OUT;
                end else if (i_sts.hit2) begin
                    o_cmd.l2_hit_upd = 1'b1;
                    n_state          = S_WR2;
                end else begin
                    o_cmd.l2_miss = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_WR2: begin
                o_cmd.l2_move = 1'b1;
                n_state       = S_WR3;
            end
            S_WR3: begin
                o_cmd.l1_fill    = w_is_fill;
                o_cmd.l1_promote = !w_is_fill;
                n_state          = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // operation of the transaction in flight
    always_ff @(posedge i_clk) begin
        if (o_cmd.load) begin
            r_op <= i_operation;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tlb_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module tlb_dp #(
    parameter int L1_ENTRIES = tlb_pkg::DEF_L1_ENTRIES,
    parameter int L2_ENTRIES = tlb_pkg::DEF_L2_ENTRIES,
    parameter int STAMP_BITS = tlb_pkg::DEF_STAMP_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire tlb_pkg::t_cmd             i_cmd,
    output tlb_pkg::t_sts                  o_sts,
    input  wire logic [tlb_pkg::OP_W-1:0]  i_operation,
    input  wire logic [tlb_pkg::VPN_W-1:0] i_virtual_page,
    input  wire logic [tlb_pkg::OFF_W-1:0] i_byte_offset,
    input  wire logic [tlb_pkg::PPN_W-1:0] i_fill_page,
    input  wire logic                      i_stall,
    output logic                           o_valid,
    output logic      [tlb_pkg::RES_W-1:0] o_outcome,
    output logic      [tlb_pkg::PA_W-1:0]  o_phys_addr,
    output logic                           o_writeback_valid,
    output logic      [tlb_pkg::PA_W-1:0]  o_writeback_address,
    output logic      [tlb_pkg::CNT_W-1:0] o_l1_hit_count,
    output logic      [tlb_pkg::CNT_W-1:0] o_l1_miss_count,
    output logic      [tlb_pkg::CNT_W-1:0] o_l2_hit_count,
    output logic      [tlb_pkg::CNT_W-1:0] o_l2_miss_count,
    output logic      [tlb_pkg::CNT_W-1:0] o_l1_inval_count,
    output logic      [tlb_pkg::CNT_W-1:0] o_l2_inval_count
);

    localparam int IW1 = $clog2(L1_ENTRIES);
    localparam int IW2 = $clog2(L2_ENTRIES);
    localparam int SB  = STAMP_BITS;
    localparam int WW  = 1 + SB + tlb_pkg::VPN_W + tlb_pkg::PPN_W;
    localparam logic [IW1-1:0] LAST1 = IW1'(L1_ENTRIES - 1);
    localparam logic [IW2-1:0] LAST2 = IW2'(L2_ENTRIES - 1);
    localparam logic [IW1-1:0] ONE1  = IW1'(1);
    localparam logic [IW2-1:0] ONE2  = IW2'(1);
    localparam logic [SB-1:0]  SONE  = SB'(1);
    localparam logic [tlb_pkg::CNT_W-1:0] CONE = {{(tlb_pkg::CNT_W-1){1'b0}}, 1'b1};
    localparam logic [tlb_pkg::OFF_W-1:0] OFF_ZERO = '0;

    // latched transaction
    logic [tlb_pkg::OP_W-1:0]  r_op;
    logic [tlb_pkg::VPN_W-1:0] r_vp;
    logic [tlb_pkg::OFF_W-1:0] r_off;
    logic [tlb_pkg::PPN_W-1:0] r_fp;
    logic                      w_wr;
    logic                      w_skip_en;

    // scan pointers and evaluation stage
    logic [IW1-1:0] r_scnt1;
    logic [IW2-1:0] r_scnt2;
    logic           r_ev1;
    logic           r_ev2;
    logic [IW1-1:0] r_eidx1;
    logic [IW2-1:0] r_eidx2;

    // valid bits, access clock, counters
    logic [L1_ENTRIES-1:0]     r_v1;
    logic [L2_ENTRIES-1:0]     r_v2;
    logic [SB-1:0]             r_clock;
    logic [SB-1:0]             w_stamp_nx;
    logic [tlb_pkg::CNT_W-1:0] r_cnt [tlb_pkg::NUM_CNT];

    // result and output register
    logic [tlb_pkg::RES_W-1:0] r_outcome;
    logic [tlb_pkg::PA_W-1:0]  r_pa;
    logic                      r_wbv;
    logic [tlb_pkg::PA_W-1:0]  r_wba;
    logic                      r_ovalid;
    logic [tlb_pkg::RES_W-1:0] r_o_outcome;
    logic [tlb_pkg::PA_W-1:0]  r_o_pa;
    logic                      r_o_wbv;
    logic [tlb_pkg::PA_W-1:0]  r_o_wba;
    logic [tlb_pkg::CNT_W-1:0] r_o_cnt [tlb_pkg::NUM_CNT];

    // memories
    logic           w_we1;
    logic [IW1-1:0] w_wa1;
    logic [WW-1:0]  w_wd1;
    logic [WW-1:0]  w_rd1;
    logic           w_we2;
    logic [IW2-1:0] w_wa2;
    logic [WW-1:0]  w_wd2;
    logic [WW-1:0]  w_rd2;

    // tracker results
    logic                      w_hit1;
    logic [IW1-1:0]            w_hidx1;
    logic                      w_hdirty1;
    logic [tlb_pkg::PPN_W-1:0] w_hppage1;
    logic [IW1-1:0]            w_vidx1;
    logic                      w_vmove1;
    logic [SB-1:0]             w_vstamp1;
    logic [tlb_pkg::VPN_W-1:0] w_vvpage1;
    logic [tlb_pkg::PPN_W-1:0] w_vppage1;
    logic                      w_hit2;
    logic [IW2-1:0]            w_hidx2;
    logic                      w_hdirty2;
    logic [tlb_pkg::PPN_W-1:0] w_hppage2;
    logic [IW2-1:0]            w_vidx2;
    logic                      w_vmove2;
    logic [SB-1:0]             w_vstamp2;
    logic [tlb_pkg::VPN_W-1:0] w_vvpage2;
    logic [tlb_pkg::PPN_W-1:0] w_vppage2;

    assign w_wr       = (r_op == tlb_pkg::OP_TR_WR) || (r_op == tlb_pkg::OP_FILL_WR);
    assign w_skip_en  = (r_op == tlb_pkg::OP_TR_RD) || (r_op == tlb_pkg::OP_TR_WR);
    assign w_stamp_nx = r_clock + SONE;

    // transaction capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_vp  <= i_virtual_page;
            r_off <= i_byte_offset;
            r_fp  <= i_fill_page;
        end
    end

    // scan pointers, read data is evaluated in the cycle after its pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_scnt1 <= '0;
            r_scnt2 <= '0;
            r_ev1   <= 1'b0;
            r_ev2   <= 1'b0;
        end else begin
            r_ev1 <= i_cmd.scan1;
            r_ev2 <= i_cmd.scan2;
            if (i_cmd.scan1) begin
                r_scnt1 <= (r_scnt1 == LAST1) ? '0 : r_scnt1 + ONE1;
            end
            if (i_cmd.scan2) begin
                r_scnt2 <= (r_scnt2 == LAST2) ? '0 : r_scnt2 + ONE2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eidx1 <= r_scnt1;
        r_eidx2 <= r_scnt2;
    end

    tlb_ram #(.WIDTH(WW), .DEPTH(L1_ENTRIES)) u_l1_ram (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (w_wa1),
        .i_wdata (w_wd1),
        .i_raddr (r_scnt1),
        .o_rdata (w_rd1)
    );

    tlb_ram #(.WIDTH(WW), .DEPTH(L2_ENTRIES)) u_l2_ram (
        .i_clk   (i_clk),
        .i_we    (w_we2),
        .i_waddr (w_wa2),
        .i_wdata (w_wd2),
        .i_raddr (r_scnt2),
        .o_rdata (w_rd2)
    );

    tlb_scan #(.IW(IW1), .SB(SB)) u_l1_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (i_cmd.load),
        .i_ev      (r_ev1),
        .i_idx     (r_eidx1),
        .i_vld     (r_v1[r_eidx1]),
        .i_key     (r_vp),
        .i_skip_en (1'b0),
        .i_dirty   (w_rd1[WW-1]),
        .i_stamp   (w_rd1[WW-2 -: SB]),
        .i_vpage   (w_rd1[tlb_pkg::VPN_W+tlb_pkg::PPN_W-1:tlb_pkg::PPN_W]),
        .i_ppage   (w_rd1[tlb_pkg::PPN_W-1:0]),
        .o_hit     (w_hit1),
        .o_hidx    (w_hidx1),
        .o_hdirty  (w_hdirty1),
        .o_hppage  (w_hppage1),
        .o_vidx    (w_vidx1),
        .o_vmove   (w_vmove1),
        .o_vstamp  (w_vstamp1),
        .o_vvpage  (w_vvpage1),
        .o_vppage  (w_vppage1)
    );

    tlb_scan #(.IW(IW2), .SB(SB)) u_l2_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (i_cmd.load),
        .i_ev      (r_ev2),
        .i_idx     (r_eidx2),
        .i_vld     (r_v2[r_eidx2]),
        .i_key     (r_vp),
        .i_skip_en (w_skip_en),
        .i_dirty   (w_rd2[WW-1]),
        .i_stamp   (w_rd2[WW-2 -: SB]),
        .i_vpage   (w_rd2[tlb_pkg::VPN_W+tlb_pkg::PPN_W-1:tlb_pkg::PPN_W]),
        .i_ppage   (w_rd2[tlb_pkg::PPN_W-1:0]),
        .o_hit     (w_hit2),
        .o_hidx    (w_hidx2),
        .o_hdirty  (w_hdirty2),
        .o_hppage  (w_hppage2),
        .o_vidx    (w_vidx2),
        .o_vmove   (w_vmove2),
        .o_vstamp  (w_vstamp2),
        .o_vvpage  (w_vvpage2),
        .o_vppage  (w_vppage2)
    );

    // l1 write port
    always_comb begin
        w_we1 = 1'b0;
        w_wa1 = '0;
        w_wd1 = '0;
        if (i_cmd.l1_hit_upd) begin
            w_we1 = 1'b1;
            w_wa1 = w_hidx1;
            w_wd1 = {w_hdirty1 | w_wr, w_stamp_nx, r_vp, w_hppage1};
        end else if (i_cmd.l1_promote) begin
            w_we1 = 1'b1;
            w_wa1 = w_vidx1;
            w_wd1 = {w_hdirty2 | w_wr, r_clock, r_vp, w_hppage2};
        end else if (i_cmd.l1_fill) begin
            w_we1 = 1'b1;
            w_wa1 = w_vidx1;
            w_wd1 = {w_wr, w_stamp_nx, r_vp, r_fp};
        end
    end

    // l2 write port
    always_comb begin
        w_we2 = 1'b0;
        w_wa2 = '0;
        w_wd2 = '0;
        if (i_cmd.l2_hit_upd) begin
            w_we2 = 1'b1;
            w_wa2 = w_hidx2;
            w_wd2 = {w_hdirty2 | w_wr, w_stamp_nx, r_vp, w_hppage2};
        end else if (i_cmd.l2_move) begin
            w_we2 = w_vmove1;
            w_wa2 = w_vidx2;
            w_wd2 = {1'b1, w_vstamp1, w_vvpage1, w_vppage1};
        end else if (i_cmd.l2_fill) begin
            w_we2 = 1'b1;
            w_wa2 = w_vidx2;
            w_wd2 = {w_wr, w_stamp_nx, r_vp, r_fp};
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= '0;
            r_v2 <= '0;
        end else begin
            if (i_cmd.l1_inval && w_hit1) begin
                r_v1[w_hidx1] <= 1'b0;
            end
            if (i_cmd.l1_promote || i_cmd.l1_fill) begin
                r_v1[w_vidx1] <= 1'b1;
            end
            if (i_cmd.l2_inval && w_hit2) begin
                r_v2[w_hidx2] <= 1'b0;
            end
            if ((i_cmd.l2_move && w_vmove1) || i_cmd.l2_fill) begin
                r_v2[w_vidx2] <= 1'b1;
            end
        end
    end

    // access clock and event counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
            for (int k = 0; k < tlb_pkg::NUM_CNT; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (i_cmd.l1_hit_upd || i_cmd.l2_hit_upd || i_cmd.l2_fill || i_cmd.l1_fill) begin
                r_clock <= w_stamp_nx;
            end
            if (i_cmd.l1_hit_upd) begin
                r_cnt[tlb_pkg::CNT_L1_HIT] <= r_cnt[tlb_pkg::CNT_L1_HIT] + CONE;
            end
            if (i_cmd.l2_hit_upd || i_cmd.l2_miss) begin
                r_cnt[tlb_pkg::CNT_L1_MISS] <= r_cnt[tlb_pkg::CNT_L1_MISS] + CONE;
            end
            if (i_cmd.l2_hit_upd) begin
                r_cnt[tlb_pkg::CNT_L2_HIT] <= r_cnt[tlb_pkg::CNT_L2_HIT] + CONE;
            end
            if (i_cmd.l2_miss) begin
                r_cnt[tlb_pkg::CNT_L2_MISS] <= r_cnt[tlb_pkg::CNT_L2_MISS] + CONE;
            end
            if (i_cmd.l1_inval && w_hit1) begin
                r_cnt[tlb_pkg::CNT_L1_INVAL] <= r_cnt[tlb_pkg::CNT_L1_INVAL] + CONE;
            end
            if (i_cmd.l2_inval && w_hit2) begin
                r_cnt[tlb_pkg::CNT_L2_INVAL] <= r_cnt[tlb_pkg::CNT_L2_INVAL] + CONE;
            end
        end
    end

    // result fields of the transaction in flight
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_outcome <= tlb_pkg::RES_WALK;
            r_pa      <= '0;
            r_wbv     <= 1'b0;
            r_wba     <= '0;
        end else if (i_cmd.l1_hit_upd) begin
            r_outcome <= tlb_pkg::RES_L1_HIT;
            r_pa      <= {w_hppage1, r_off};
        end else if (i_cmd.l2_hit_upd) begin
            r_outcome <= tlb_pkg::RES_L2_HIT;
            r_pa      <= {w_hppage2, r_off};
        end else if (i_cmd.l2_miss) begin
            r_outcome <= tlb_pkg::RES_WALK;
        end else if (i_cmd.l2_inval) begin
            r_outcome <= tlb_pkg::RES_INVAL;
            if (w_hit2 && w_hdirty2) begin
                r_wbv <= 1'b1;
                r_wba <= {w_hppage2, OFF_ZERO};
            end
        end else if (i_cmd.l2_fill) begin
            r_outcome <= tlb_pkg::RES_FILLED;
            r_pa      <= {r_fp, r_off};
            if (w_vmove2) begin
                r_wbv <= 1'b1;
                r_wba <= {w_vppage2, OFF_ZERO};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_outcome <= r_outcome;
            r_o_pa      <= r_pa;
            r_o_wbv     <= r_wbv;
            r_o_wba     <= r_wba;
            for (int k = 0; k < tlb_pkg::NUM_CNT; k++) begin
                r_o_cnt[k] <= r_cnt[k];
            end
        end
    end

    // status to the controller
    always_comb begin
        o_sts.last1    = (r_scnt1 == LAST1);
        o_sts.last2    = (r_scnt2 == LAST2);
        o_sts.hit1     = w_hit1;
        o_sts.hit2     = w_hit2;
        o_sts.out_free = !r_ovalid || !i_stall;
    end

    assign o_valid             = r_ovalid;
    assign o_outcome           = r_o_outcome;
    assign o_phys_addr         = r_o_pa;
    assign o_writeback_valid   = r_o_wbv;
    assign o_writeback_address = r_o_wba;
    assign o_l1_hit_count      = r_o_cnt[tlb_pkg::CNT_L1_HIT];
    assign o_l1_miss_count     = r_o_cnt[tlb_pkg::CNT_L1_MISS];
    assign o_l2_hit_count      = r_o_cnt[tlb_pkg::CNT_L2_HIT];
    assign o_l2_miss_count     = r_o_cnt[tlb_pkg::CNT_L2_MISS];
    assign o_l1_inval_count    = r_o_cnt[tlb_pkg::CNT_L1_INVAL];
    assign o_l2_inval_count    = r_o_cnt[tlb_pkg::CNT_L2_INVAL];

endmodule

`default_nettype wire

[hw/rtl/two_level_tlb_lru_top.sv]
// two-level fully associative tlb with lru stamps and dirty bits
// input channel: i_valid / o_stall carry operation, virtual_page, byte_offset
// and fill_page; a transaction is taken when i_valid is high and o_stall low.
// operations 5 to 7 are taken and dropped without a result.
// output channel: o_valid / i_stall carry outcome, addresses, write-back and
// the six wrapping event counters; one result per valid operation.
// each level is scanned one entry per cycle through its ram port; an l1
// hit ends after the l1 scan, while a walk, an invalidate, a fill or an l2
// hit also scans the l2.
// one transaction is in flight at a time; o_stall stays high until its
// result is in the output register.
// a full output register held by i_stall delays the next result, but a new
// transaction is taken as soon as the previous one has been handed over.
// reset (i_rst_n low, synchronous) empties both levels, zeros the access
// clock and all counters, and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module two_level_tlb_lru_top #(
    parameter int L1_ENTRIES = tlb_pkg::DEF_L1_ENTRIES,
    parameter int L2_ENTRIES = tlb_pkg::DEF_L2_ENTRIES,
    parameter int STAMP_BITS = tlb_pkg::DEF_STAMP_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [tlb_pkg::OP_W-1:0]  i_operation,
    input  wire logic [tlb_pkg::VPN_W-1:0] i_virtual_page,
    input  wire logic [tlb_pkg::OFF_W-1:0] i_byte_offset,
    input  wire logic [tlb_pkg::PPN_W-1:0] i_fill_page,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic      [tlb_pkg::RES_W-1:0] o_outcome,
    output logic      [tlb_pkg::PA_W-1:0]  o_phys_addr,
    output logic                           o_writeback_valid,
    output logic      [tlb_pkg::PA_W-1:0]  o_writeback_address,
    output logic      [tlb_pkg::CNT_W-1:0] o_l1_hit_count,
    output logic      [tlb_pkg::CNT_W-1:0] o_l1_miss_count,
    output logic      [tlb_pkg::CNT_W-1:0] o_l2_hit_count,
    output logic      [tlb_pkg::CNT_W-1:0] o_l2_miss_count,
    output logic      [tlb_pkg::CNT_W-1:0] o_l1_inval_count,
    output logic      [tlb_pkg::CNT_W-1:0] o_l2_inval_count
);

    tlb_pkg::t_cmd w_cmd;
    tlb_pkg::t_sts w_sts;

    tlb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_stall     (o_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tlb_dp #(
        .L1_ENTRIES (L1_ENTRIES),
        .L2_ENTRIES (L2_ENTRIES),
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_operation         (i_operation),
        .i_virtual_page      (i_virtual_page),
        .i_byte_offset       (i_byte_offset),
        .i_fill_page         (i_fill_page),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_outcome           (o_outcome),
        .o_phys_addr         (o_phys_addr),
        .o_writeback_valid   (o_writeback_valid),
        .o_writeback_address (o_writeback_address),
        .o_l1_hit_count      (o_l1_hit_count),
        .o_l1_miss_count     (o_l1_miss_count),
        .o_l2_hit_count      (o_l2_hit_count),
        .o_l2_miss_count     (o_l2_miss_count),
        .o_l1_inval_count    (o_l1_inval_count),
        .o_l2_inval_count    (o_l2_inval_count)
    );

`ifndef NO_ASSERTIONS
    // a valid operation, once taken, holds off the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_operation <= tlb_pkg::OP_FILL_WR)) |=> o_stall)
        else $error("tlb not busy after accepting an operation");

    // a result is loaded only when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_valid || !i_stall))
        else $error("tlb result loaded over a stalled result");

    // the block frees up only by handing a result over
    a_free_by_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_stall) && $past(i_rst_n)) |-> ($past(w_cmd.out_load) && o_valid))
        else $error("tlb left busy without a result");
`endif

endmodule

`default_nettype wire

[tb/two_level_tlb_lru_top_tb.sv]
`timescale 1ns / 1ps

module two_level_tlb_lru_top_tb;

    localparam int OP_W  = tlb_pkg::OP_W;
    localparam int RES_W = tlb_pkg::RES_W;
    localparam int VPN_W = tlb_pkg::VPN_W;
    localparam int OFF_W = tlb_pkg::OFF_W;
    localparam int PPN_W = tlb_pkg::PPN_W;
    localparam int PA_W  = tlb_pkg::PA_W;
    localparam int CNT_W = tlb_pkg::CNT_W;
    localparam int NUM_CNT = tlb_pkg::NUM_CNT;
    localparam int N1 = tlb_pkg::DEF_L1_ENTRIES;
    localparam int N2 = tlb_pkg::DEF_L2_ENTRIES;
    localparam int SB = tlb_pkg::DEF_STAMP_BITS;
    localparam int POOL = 96;
    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_CYCLES = 4 * (N1 + N2 + 8);

    typedef struct {
        logic [RES_W-1:0] outcome;
        logic [PA_W-1:0]  paddr;
        logic             wb_valid;
        logic [PA_W-1:0]  wb_addr;
        logic [CNT_W-1:0] cnt [NUM_CNT];
    } t_tlb_resp;

    // shadow copy of both tlb levels, predicts each response
    class t_tlb_shadow;
        logic             v1 [N1];
        logic             d1 [N1];
        logic [SB-1:0]    s1 [N1];
        logic [VPN_W-1:0] vp1 [N1];
        logic [PPN_W-1:0] pp1 [N1];
        logic             v2 [N2];
        logic             d2 [N2];
        logic [SB-1:0]    s2 [N2];
        logic [VPN_W-1:0] vp2 [N2];
        logic [PPN_W-1:0] pp2 [N2];
        logic [SB-1:0]    access_clk;
        logic [CNT_W-1:0] counters [NUM_CNT];
        t_tlb_resp        pending [$];
        logic [RES_W-1:0] last_outcome;
        int               errors;

        function new();
            for (int i = 0; i < N1; i++) begin
                v1[i] = 0; d1[i] = 0; s1[i] = 0; vp1[i] = 0; pp1[i] = 0;
            end
            for (int i = 0; i < N2; i++) begin
                v2[i] = 0; d2[i] = 0; s2[i] = 0; vp2[i] = 0; pp2[i] = 0;
            end
            for (int i = 0; i < NUM_CNT; i++) counters[i] = 0;
            access_clk = 0;
            errors = 0;
            last_outcome = tlb_pkg::RES_INVAL;
        endfunction

        function logic [SB-1:0] bump_stamp();
            access_clk = access_clk + 1'b1;
            return access_clk;
        endfunction

        function logic [PA_W-1:0] base_of(logic [PPN_W-1:0] pp);
            return {pp, {OFF_W{1'b0}}};
        endfunction

        function int l1_victim();
            int best;
            best = 0;
            for (int i = 0; i < N1; i++) if (!v1[i]) return i;
            for (int i = 1; i < N1; i++) if (s1[i] < s1[best]) best = i;
            return best;
        endfunction

        function int l2_victim(int skip);
            int best;
            best = -1;
            for (int i = 0; i < N2; i++) if (i != skip && !v2[i]) return i;
            for (int i = 0; i < N2; i++) begin
                if (i == skip) continue;
                if (best < 0 || s2[i] < s2[best]) best = i;
            end
            return (best < 0) ? 0 : best;
        endfunction

        function int l1_find(logic [VPN_W-1:0] vp);
            for (int i = 0; i < N1; i++) if (v1[i] && vp1[i] == vp) return i;
            return -1;
        endfunction

        function int l2_find(logic [VPN_W-1:0] vp);
            for (int i = 0; i < N2; i++) if (v2[i] && vp2[i] == vp) return i;
            return -1;
        endfunction

        // update shadow state for an accepted request and queue its response
        function void note_request(logic [OP_W-1:0] op, logic [VPN_W-1:0] vp,
                                   logic [OFF_W-1:0] off, logic [PPN_W-1:0] fp);
            t_tlb_resp r;
            int h, v, w;
            logic wr;
            wr = (op == tlb_pkg::OP_TR_WR) || (op == tlb_pkg::OP_FILL_WR);
            r.outcome = tlb_pkg::RES_L1_HIT;
            r.paddr = 0;
            r.wb_valid = 0;
            r.wb_addr = 0;
            if (op > tlb_pkg::OP_FILL_WR) return;
            if (op == tlb_pkg::OP_TR_RD || op == tlb_pkg::OP_TR_WR) begin
                h = l1_find(vp);
                if (h >= 0) begin
                    counters[tlb_pkg::CNT_L1_HIT]++;
                    s1[h] = bump_stamp();
                    if (wr) d1[h] = 1;
                    r.outcome = tlb_pkg::RES_L1_HIT;
                    r.paddr = base_of(pp1[h]) | off;
                end else begin
                    counters[tlb_pkg::CNT_L1_MISS]++;
                    h = l2_find(vp);
                    if (h >= 0) begin
                        counters[tlb_pkg::CNT_L2_HIT]++;
                        s2[h] = bump_stamp();
                        if (wr) d2[h] = 1;
                        v = l1_victim();
                        // dirty l1 victim moves down, never over the hit slot
                        if (v1[v] && d1[v]) begin
                            w = l2_victim(h);
                            v2[w] = 1; d2[w] = 1; s2[w] = s1[v];
                            vp2[w] = vp1[v]; pp2[w] = pp1[v];
                        end
                        v1[v] = 1; d1[v] = d2[h]; s1[v] = s2[h];
                        vp1[v] = vp2[h]; pp1[v] = pp2[h];
                        r.outcome = tlb_pkg::RES_L2_HIT;
                        r.paddr = base_of(pp2[h]) | off;
                    end else begin
                        counters[tlb_pkg::CNT_L2_MISS]++;
                        r.outcome = tlb_pkg::RES_WALK;
                    end
                end
            end else if (op == tlb_pkg::OP_INVAL) begin
                h = l1_find(vp);
                if (h >= 0) begin
                    counters[tlb_pkg::CNT_L1_INVAL]++;
                    v1[h] = 0;
                end
                h = l2_find(vp);
                if (h >= 0) begin
                    counters[tlb_pkg::CNT_L2_INVAL]++;
                    if (d2[h]) begin
                        r.wb_valid = 1;
                        r.wb_addr = base_of(pp2[h]);
                    end
                    v2[h] = 0;
                end
                r.outcome = tlb_pkg::RES_INVAL;
            end else begin
                w = l2_victim(-1);
                if (v2[w] && d2[w]) begin
                    r.wb_valid = 1;
                    r.wb_addr = base_of(pp2[w]);
                end
                v2[w] = 1; d2[w] = wr; vp2[w] = vp; pp2[w] = fp;
                s2[w] = bump_stamp();
                v = l1_victim();
                v1[v] = 1; d1[v] = wr; vp1[v] = vp; pp1[v] = fp;
                s1[v] = bump_stamp();
                r.outcome = tlb_pkg::RES_FILLED;
                r.paddr = base_of(fp) | off;
            end
            for (int i = 0; i < NUM_CNT; i++) r.cnt[i] = counters[i];
            last_outcome = r.outcome;
            pending.push_back(r);
        endfunction

        function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // compare one delivered response against the oldest prediction
        function void check_response(t_tlb_resp got);
            t_tlb_resp e;
            if (pending.size() == 0) begin
                $error("unexpected response: outcome %0d", got.outcome);
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("outcome", e.outcome, got.outcome);
            cmp("phys_addr", e.paddr, got.paddr);
            cmp("writeback_valid", e.wb_valid, got.wb_valid);
            cmp("writeback_address", e.wb_addr, got.wb_addr);
            cmp("l1_hit_count", e.cnt[tlb_pkg::CNT_L1_HIT], got.cnt[tlb_pkg::CNT_L1_HIT]);
            cmp("l1_miss_count", e.cnt[tlb_pkg::CNT_L1_MISS], got.cnt[tlb_pkg::CNT_L1_MISS]);
            cmp("l2_hit_count", e.cnt[tlb_pkg::CNT_L2_HIT], got.cnt[tlb_pkg::CNT_L2_HIT]);
            cmp("l2_miss_count", e.cnt[tlb_pkg::CNT_L2_MISS], got.cnt[tlb_pkg::CNT_L2_MISS]);
            cmp("l1_inval_count", e.cnt[tlb_pkg::CNT_L1_INVAL],
                got.cnt[tlb_pkg::CNT_L1_INVAL]);
            cmp("l2_inval_count", e.cnt[tlb_pkg::CNT_L2_INVAL],
                got.cnt[tlb_pkg::CNT_L2_INVAL]);
        endfunction
    endclass

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             i_valid = 0;
    logic             o_stall;
    logic [OP_W-1:0]  i_operation = tlb_pkg::OP_TR_RD;
    logic [VPN_W-1:0] i_virtual_page = 0;
    logic [OFF_W-1:0] i_byte_offset = 0;
    logic [PPN_W-1:0] i_fill_page = 0;
    logic             o_valid;
    logic             i_stall = 1;
    logic [RES_W-1:0] o_outcome;
    logic [PA_W-1:0]  o_phys_addr;
    logic             o_writeback_valid;
    logic [PA_W-1:0]  o_writeback_address;
    logic [CNT_W-1:0] o_l1_hit_count, o_l1_miss_count, o_l2_hit_count;
    logic [CNT_W-1:0] o_l2_miss_count, o_l1_inval_count, o_l2_inval_count;

    two_level_tlb_lru_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation), .i_virtual_page(i_virtual_page),
        .i_byte_offset(i_byte_offset), .i_fill_page(i_fill_page),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_outcome(o_outcome), .o_phys_addr(o_phys_addr),
        .o_writeback_valid(o_writeback_valid),
        .o_writeback_address(o_writeback_address),
        .o_l1_hit_count(o_l1_hit_count), .o_l1_miss_count(o_l1_miss_count),
        .o_l2_hit_count(o_l2_hit_count), .o_l2_miss_count(o_l2_miss_count),
        .o_l1_inval_count(o_l1_inval_count), .o_l2_inval_count(o_l2_inval_count)
    );

    t_tlb_shadow      shadow = new();
    logic [VPN_W-1:0] page_pool [POOL];
    bit               no_idle = 0;
    bit               long_hold_req = 0;
    bit               in_reset = 1;

    always #6 i_clk = ~i_clk;

    // response side: random stall per transaction, one long hold on request
    initial begin
        int n;
        @(posedge i_clk);
        while (in_reset) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                n = 400;
                long_hold_req = 0;
            end else begin
                n = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (n > 0) begin
                i_stall <= 1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 0;
            @(posedge i_clk);
            while (!(o_valid && !i_stall)) @(posedge i_clk);
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        t_tlb_resp got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.outcome = o_outcome;
            got.paddr = o_phys_addr;
            got.wb_valid = o_writeback_valid;
            got.wb_addr = o_writeback_address;
            got.cnt[tlb_pkg::CNT_L1_HIT] = o_l1_hit_count;
            got.cnt[tlb_pkg::CNT_L1_MISS] = o_l1_miss_count;
            got.cnt[tlb_pkg::CNT_L2_HIT] = o_l2_hit_count;
            got.cnt[tlb_pkg::CNT_L2_MISS] = o_l2_miss_count;
            got.cnt[tlb_pkg::CNT_L1_INVAL] = o_l1_inval_count;
            got.cnt[tlb_pkg::CNT_L2_INVAL] = o_l2_inval_count;
            shadow.check_response(got);
        end
    end

    // drive one request transaction and wait for its acceptance
    task automatic send_req(logic [OP_W-1:0] op, logic [VPN_W-1:0] vp,
                            logic [OFF_W-1:0] off, logic [PPN_W-1:0] fp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_operation <= op;
        i_virtual_page <= vp;
        i_byte_offset <= off;
        i_fill_page <= fp;
        i_valid <= 1;
        @(posedge i_clk);
        while (!(i_valid && !o_stall)) @(posedge i_clk);
        shadow.note_request(op, vp, off, fp);
    endtask

    task automatic wait_drained();
        i_valid <= 0;
        while (shadow.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [OFF_W-1:0] rand_off();
        return OFF_W'($urandom());
    endfunction

    function automatic logic [PPN_W-1:0] rand_ppn();
        return PPN_W'($urandom());
    endfunction

    function automatic logic [VPN_W-1:0] rand_vpn();
        return VPN_W'({$urandom(), $urandom()});
    endfunction

    initial begin
        int count, sel, pick;
        logic [VPN_W-1:0] vp;
        logic wr;
        for (int i = 0; i < POOL; i++) page_pool[i] = rand_vpn();
        page_pool[0] = '0;
        page_pool[1] = '1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        in_reset = 0;

        // directed: extremes, every operation and special cases
        send_req(tlb_pkg::OP_TR_RD, '0, '0, '0);
        send_req(tlb_pkg::OP_FILL_RD, '0, '0, '0);
        send_req(tlb_pkg::OP_TR_RD, '0, '1, '1);
        send_req(tlb_pkg::OP_TR_WR, '1, '1, '0);
        send_req(tlb_pkg::OP_FILL_WR, '1, '1, '1);
        send_req(tlb_pkg::OP_TR_WR, '1, '0, '0);
        send_req(tlb_pkg::OP_FILL_RD, '1, 12'h5a5, 28'h1234567);
        send_req(tlb_pkg::OP_TR_RD, '1, 12'h0ff, '0);
        send_req(tlb_pkg::OP_INVAL, '1, '0, '0);
        send_req(tlb_pkg::OP_TR_RD, '1, '0, '0);
        send_req(tlb_pkg::OP_INVAL, '1, '0, '0);
        send_req(tlb_pkg::OP_INVAL, 36'h123456789, '0, '0);
        send_req(3'd5, '1, '1, '1);
        send_req(3'd6, '0, '0, '0);
        send_req(3'd7, '1, '0, '1);
        // fill the l1 with dirty entries so promotion pushes victims down
        for (int i = 2; i < 20; i++) begin
            send_req(tlb_pkg::OP_FILL_WR, page_pool[i], '0, rand_ppn());
        end
        send_req(tlb_pkg::OP_TR_WR, page_pool[2], '1, '0);
        send_req(tlb_pkg::OP_TR_RD, '0, '0, '0);

        // pressure: long response hold while requests keep coming
        long_hold_req = 1;
        for (int i = 0; i < 4; i++) send_req(tlb_pkg::OP_TR_RD, page_pool[i], rand_off(), '0);
        wait_drained();

        count = 0;
        while (count < RANDOM_ITEMS) begin
            no_idle = (count >= 600) && (count < 700);
            if (count == 1200) wait_drained();
            sel = $urandom_range(0, 99);
            pick = $urandom_range(0, POOL - 1);
            vp = page_pool[pick];
            wr = 1'($urandom_range(0, 1));
            if (sel < 70) begin
                // translate, walk and fill on a miss, retranslate
                send_req(wr ? tlb_pkg::OP_TR_WR : tlb_pkg::OP_TR_RD, vp, rand_off(),
                         rand_ppn());
                count++;
                if (shadow.last_outcome == tlb_pkg::RES_WALK) begin
                    send_req($urandom_range(0, 1) ? tlb_pkg::OP_FILL_WR : tlb_pkg::OP_FILL_RD,
                             vp, rand_off(), rand_ppn());
                    count++;
                    if ($urandom_range(0, 1)) begin
                        send_req(tlb_pkg::OP_TR_RD, vp, rand_off(), rand_ppn());
                        count++;
                    end
                end
            end else if (sel < 85) begin
                send_req(tlb_pkg::OP_INVAL, vp, rand_off(), rand_ppn());
                count++;
            end else if (sel < 92) begin
                // fill of a possibly present page gives duplicates
                send_req(wr ? tlb_pkg::OP_FILL_WR : tlb_pkg::OP_FILL_RD, vp, rand_off(),
                         rand_ppn());
                count++;
            end else if (sel < 97) begin
                send_req(OP_W'($urandom_range(tlb_pkg::OP_TR_RD, tlb_pkg::OP_FILL_WR)),
                         rand_vpn(), rand_off(), rand_ppn());
                count++;
            end else begin
                send_req(OP_W'($urandom_range(5, 7)), rand_vpn(), rand_off(), rand_ppn());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.pending.size() != 0) begin
            $error("expected responses left over: %0d", shadow.pending.size());
            shadow.errors++;
        end
        if (shadow.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
